// ===== src/sptest_pkg.sv =====
package sptest_pkg;

   localparam int COORD_BITS = 16;
   localparam int EDGE_BITS  = 16;

   // one extra bit for a coordinate difference, products of two differences,
   // and one more bit for the difference of two products
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   // orientation tests: A against each end of B, then B against each end of A
   localparam int NUM_TESTS = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [EDGE_BITS-1:0]         edge_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;

   typedef struct packed {
      coord_type a_left_x;
      coord_type a_left_y;
      coord_type a_right_x;
      coord_type a_right_y;
      coord_type b_left_x;
      coord_type b_left_y;
      coord_type b_right_x;
      coord_type b_right_y;
      edge_type  a_edge;
      edge_type  b_edge;
      edge_type  ring_first;
      edge_type  ring_last;
   } req_type;

   typedef struct packed {
      logic crossing;
      logic neighbours;
   } rsp_type;

endpackage

// ===== src/segment_pair_intersection_test_core.sv =====
// Segment pair intersection test. One item enters per cycle unless stalled;
// the four register stages are: coordinate differences with the ring
// adjacency and overlap checks, the eight orientation products, the
// cross-product signs, and the result register. A stall on the result side
// holds only the stages that are full, so bubbles close up and input is
// taken while a result waits as long as some stage is empty. Edges that are
// neighbours in the ring of the first segment (with wrap from the last edge
// to the first) report neighbours and no crossing; otherwise exact integer
// orientation tests decide, and collinear segments are checked for overlap
// on x, or on y when the first segment is vertical.
module segment_pair_intersection_test_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sptest_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sptest_pkg::rsp_type  rsp_data
);

   function automatic sptest_pkg::diff_type coord_sub(
      input sptest_pkg::coord_type a,
      input sptest_pkg::coord_type b
   );
      coord_sub = sptest_pkg::DIFF_BITS'(a) - sptest_pkg::DIFF_BITS'(b);
   endfunction

   // both q values beyond the same end of the p interval
   function automatic logic outside(
      input sptest_pkg::coord_type p1,
      input sptest_pkg::coord_type p2,
      input sptest_pkg::coord_type q1,
      input sptest_pkg::coord_type q2
   );
      logic lo_hi;
      logic hi_lo;
      lo_hi = (p1 > p2) && (((q1 > p1) && (q2 > p1)) || ((q1 < p2) && (q2 < p2)));
      hi_lo = (p1 < p2) && (((q1 > p2) && (q2 > p2)) || ((q1 < p1) && (q2 < p1)));
      outside = lo_hi || hi_lo;
   endfunction

   // sign pair rejects a hit unless both are zero or they are opposite
   function automatic logic rejects(
      input logic l_pos,
      input logic l_neg,
      input logic r_pos,
      input logic r_neg
   );
      logic both_zero;
      logic opposite;
      both_zero = !l_pos && !l_neg && !r_pos && !r_neg;
      opposite  = (l_pos && r_neg) || (l_neg && r_pos);
      rejects   = !both_zero && !opposite;
   endfunction

   logic ready1;
   logic ready2;
   logic ready3;
   logic ready4;

   // stage 1: differences, adjacency, overlap
   logic                  valid1_ff;
   sptest_pkg::diff_type  mul_a1_ff [sptest_pkg::NUM_TESTS];
   sptest_pkg::diff_type  mul_b1_ff [sptest_pkg::NUM_TESTS];
   sptest_pkg::diff_type  sub_a1_ff [sptest_pkg::NUM_TESTS];
   sptest_pkg::diff_type  sub_b1_ff [sptest_pkg::NUM_TESTS];
   sptest_pkg::diff_type  mul_a1_in [sptest_pkg::NUM_TESTS];
   sptest_pkg::diff_type  mul_b1_in [sptest_pkg::NUM_TESTS];
   sptest_pkg::diff_type  sub_a1_in [sptest_pkg::NUM_TESTS];
   sptest_pkg::diff_type  sub_b1_in [sptest_pkg::NUM_TESTS];
   logic                  adj1_ff;
   logic                  adj1_in;
   logic                  overlap1_ff;
   logic                  overlap1_in;

   // stage 2: products
   logic                  valid2_ff;
   sptest_pkg::prod_type  prod_a2_ff [sptest_pkg::NUM_TESTS];
   sptest_pkg::prod_type  prod_b2_ff [sptest_pkg::NUM_TESTS];
   sptest_pkg::prod_type  prod_a2_in [sptest_pkg::NUM_TESTS];
   sptest_pkg::prod_type  prod_b2_in [sptest_pkg::NUM_TESTS];
   logic                  adj2_ff;
   logic                  overlap2_ff;

   // stage 3: orientation signs
   logic                           valid3_ff;
   logic [sptest_pkg::NUM_TESTS-1:0] pos3_ff;
   logic [sptest_pkg::NUM_TESTS-1:0] neg3_ff;
   logic [sptest_pkg::NUM_TESTS-1:0] pos3_in;
   logic [sptest_pkg::NUM_TESTS-1:0] neg3_in;
   logic                           adj3_ff;
   logic                           overlap3_ff;

   // stage 4: result
   logic                 valid4_ff;
   sptest_pkg::rsp_type  rsp4_ff;
   sptest_pkg::rsp_type  rsp4_in;

   assign ready4 = !valid4_ff || !rsp_stall;
   assign ready3 = !valid3_ff || ready4;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;

   assign req_stall = !ready1;
   assign rsp_valid = valid4_ff;
   assign rsp_data  = rsp4_ff;

   // ---- stage 1 logic
   logic [sptest_pkg::EDGE_BITS:0] succ_a;
   logic [sptest_pkg::EDGE_BITS:0] succ_b;
   logic                           in_ring;
   logic                           out_x;
   logic                           out_y;

   always_comb begin
      // A against B left end
      mul_a1_in[0] = coord_sub(req_data.a_right_x, req_data.a_left_x);
      mul_b1_in[0] = coord_sub(req_data.b_left_y, req_data.a_left_y);
      sub_a1_in[0] = coord_sub(req_data.b_left_x, req_data.a_left_x);
      sub_b1_in[0] = coord_sub(req_data.a_right_y, req_data.a_left_y);
      // A against B right end
      mul_a1_in[1] = coord_sub(req_data.a_right_x, req_data.a_left_x);
      mul_b1_in[1] = coord_sub(req_data.b_right_y, req_data.a_left_y);
      sub_a1_in[1] = coord_sub(req_data.b_right_x, req_data.a_left_x);
      sub_b1_in[1] = coord_sub(req_data.a_right_y, req_data.a_left_y);
      // B against A left end
      mul_a1_in[2] = coord_sub(req_data.b_right_x, req_data.b_left_x);
      mul_b1_in[2] = coord_sub(req_data.a_left_y, req_data.b_left_y);
      sub_a1_in[2] = coord_sub(req_data.a_left_x, req_data.b_left_x);
      sub_b1_in[2] = coord_sub(req_data.b_right_y, req_data.b_left_y);
      // B against A right end
      mul_a1_in[3] = coord_sub(req_data.b_right_x, req_data.b_left_x);
      mul_b1_in[3] = coord_sub(req_data.a_right_y, req_data.b_left_y);
      sub_a1_in[3] = coord_sub(req_data.a_right_x, req_data.b_left_x);
      sub_b1_in[3] = coord_sub(req_data.b_right_y, req_data.b_left_y);

      // successor wraps from the last edge of the ring to the first
      succ_a = (req_data.a_edge == req_data.ring_last)
               ? {1'b0, req_data.ring_first}
               : {1'b0, req_data.a_edge} + (sptest_pkg::EDGE_BITS+1)'(1);
      succ_b = (req_data.b_edge == req_data.ring_last)
               ? {1'b0, req_data.ring_first}
               : {1'b0, req_data.b_edge} + (sptest_pkg::EDGE_BITS+1)'(1);
      in_ring = (req_data.ring_first <= req_data.ring_last)
                && (req_data.a_edge >= req_data.ring_first)
                && (req_data.a_edge <= req_data.ring_last)
                && (req_data.b_edge >= req_data.ring_first)
                && (req_data.b_edge <= req_data.ring_last);
      adj1_in = in_ring && ((succ_a == {1'b0, req_data.b_edge})
                            || (succ_b == {1'b0, req_data.a_edge}));

      out_x = outside(req_data.a_left_x, req_data.a_right_x,
                      req_data.b_left_x, req_data.b_right_x);
      out_y = outside(req_data.a_left_y, req_data.a_right_y,
                      req_data.b_left_y, req_data.b_right_y);
      overlap1_in = (req_data.a_left_x != req_data.a_right_x) ? !out_x : !out_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (ready1) begin
         valid1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         mul_a1_ff   <= mul_a1_in;
         mul_b1_ff   <= mul_b1_in;
         sub_a1_ff   <= sub_a1_in;
         sub_b1_ff   <= sub_b1_in;
         adj1_ff     <= adj1_in;
         overlap1_ff <= overlap1_in;
      end
   end

   // ---- stage 2 logic
   always_comb begin
      for (int i = 0; i < sptest_pkg::NUM_TESTS; i++) begin
         prod_a2_in[i] = sptest_pkg::PROD_BITS'(mul_a1_ff[i])
                         * sptest_pkg::PROD_BITS'(mul_b1_ff[i]);
         prod_b2_in[i] = sptest_pkg::PROD_BITS'(sub_a1_ff[i])
                         * sptest_pkg::PROD_BITS'(sub_b1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (ready2) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         prod_a2_ff  <= prod_a2_in;
         prod_b2_ff  <= prod_b2_in;
         adj2_ff     <= adj1_ff;
         overlap2_ff <= overlap1_ff;
      end
   end

   // ---- stage 3 logic
   sptest_pkg::cross_type cross3 [sptest_pkg::NUM_TESTS];

   always_comb begin
      for (int i = 0; i < sptest_pkg::NUM_TESTS; i++) begin
         cross3[i]  = sptest_pkg::CROSS_BITS'(prod_a2_ff[i])
                      - sptest_pkg::CROSS_BITS'(prod_b2_ff[i]);
         neg3_in[i] = cross3[i][sptest_pkg::CROSS_BITS-1];
         pos3_in[i] = !cross3[i][sptest_pkg::CROSS_BITS-1]
                      && (cross3[i] != sptest_pkg::CROSS_BITS'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (ready3) begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         pos3_ff     <= pos3_in;
         neg3_ff     <= neg3_in;
         adj3_ff     <= adj2_ff;
         overlap3_ff <= overlap2_ff;
      end
   end

   // ---- stage 4 logic
   logic reject_a;
   logic reject_b;
   logic collinear_b;

   always_comb begin
      reject_a    = rejects(pos3_ff[0], neg3_ff[0], pos3_ff[1], neg3_ff[1]);
      reject_b    = rejects(pos3_ff[2], neg3_ff[2], pos3_ff[3], neg3_ff[3]);
      collinear_b = !pos3_ff[2] && !neg3_ff[2] && !pos3_ff[3] && !neg3_ff[3];
      rsp4_in.neighbours = adj3_ff;
      rsp4_in.crossing   = !adj3_ff && !reject_a && !reject_b
                           && (!collinear_b || overlap3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else if (ready4) begin
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         rsp4_ff <= rsp4_in;
      end
   end

endmodule

// ===== src/sptest_check.sv =====
module sptest_check (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input sptest_pkg::req_type  req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input sptest_pkg::rsp_type  rsp_data
);

   // a stalled result item stays and keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   // skipped neighbours never report a crossing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.neighbours && rsp_data.crossing))
      else $error("neighbours reported together with crossing");

   // reset empties the pipeline
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item valid right after reset");

   // with nothing waiting at the output the pipeline can always take an item
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output is empty");

endmodule

bind segment_pair_intersection_test_core sptest_check u_sptest_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
